FILE: hdl/g2h_pkg.sv
// Package for the Gregorian to tabular Hijri date converter.
// Holds the fixed-point constants and the two month lookup tables.
// No dependencies.
package g2h_pkg;

  localparam int unsigned PIPE_STAGES = 11;

  localparam logic [10:0] YEAR_MUL     = 11'd1461;
  localparam logic [14:0] YEAR_BASE    = 15'd4716;
  localparam logic [12:0] CENT_RECIP   = 13'd5243;
  localparam int unsigned CENT_SHIFT   = 19;
  localparam logic [24:0] JD_OFFSET    = 25'd1949961;
  localparam logic [29:0] HY_BIAS      = 30'd10646;
  localparam logic [13:0] HY_DIV       = 14'd10631;
  localparam logic [14:0] HY_RECIP     = 15'd25250;
  localparam int unsigned HY_SHIFT     = 28;
  localparam logic [15:0] D30_RECIP    = 16'd34952;
  localparam int unsigned D30_SHIFT    = 20;
  localparam logic [4:0]  D30_DIV      = 5'd30;
  localparam logic [9:0]  HYEAR_DAYS   = 10'd354;
  localparam logic [5:0]  HMONTH_LEN2  = 6'd59;
  localparam logic [4:0]  HMONTH_BIAS  = 5'd28;
  localparam logic [4:0]  HDAY_MAX     = 5'd30;

  typedef logic [8:0] gday_t;

  function automatic gday_t month_days_f(input logic [3:0] m);
    gday_t d;
    case (m)
      4'd0:    d = 9'd30;
      4'd1:    d = 9'd61;
      4'd2:    d = 9'd91;
      4'd3:    d = 9'd122;
      4'd4:    d = 9'd153;
      4'd5:    d = 9'd183;
      4'd6:    d = 9'd214;
      4'd7:    d = 9'd244;
      4'd8:    d = 9'd275;
      4'd9:    d = 9'd306;
      4'd10:   d = 9'd336;
      4'd11:   d = 9'd367;
      4'd12:   d = 9'd397;
      4'd13:   d = 9'd428;
      4'd14:   d = 9'd459;
      default: d = 9'd489;
    endcase
    return d;
  endfunction

  function automatic gday_t hmonth_start_f(input logic [3:0] hm);
    gday_t d;
    case (hm)
      4'd2:    d = 9'd29;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd88;
      4'd5:    d = 9'd118;
      4'd6:    d = 9'd147;
      4'd7:    d = 9'd177;
      4'd8:    d = 9'd206;
      4'd9:    d = 9'd236;
      4'd10:   d = 9'd265;
      4'd11:   d = 9'd295;
      4'd12:   d = 9'd324;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: hdl/gregorian_to_hijri_tabular.sv
// Gregorian to tabular Hijri date converter, eleven-stage pipeline.
// Depends on g2h_pkg for constants and month tables.
//
// Usage:
//   Input channel in_*: one request carries a Gregorian year, month and day.
//   It is taken at a rising edge with in_valid high and in_stall low.
//   Result channel out_*: one Hijri day, month and year per request, in
//   order, offered with out_valid and taken when out_stall is low.
//   Configuration: cfg_we writes cfg_wdata into the signed day adjustment,
//   added to the Julian day ahead of the conversion. Write only when idle.
// Throughput: one request per cycle while out_stall stays low; the depth is set
//   by the two reciprocal divisions (by 10631 and by 30) with their multiply
//   and correction steps.
// Reset (rst_n low, synchronous): all stage valids clear and the day
//   adjustment returns to zero.
// Stall: a stalled result holds in the last stage; each stage holds only
//   while it is full and the one after it cannot advance, so empty stages
//   keep filling and in_stall rises only once every stage is full.
module gregorian_to_hijri_tabular (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] in_greg_year,
  input  logic [3:0]  in_greg_month,
  input  logic [4:0]  in_greg_day,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_hijri_day,
  output logic [3:0]  out_hijri_month,
  output logic [13:0] out_hijri_year
);
  import g2h_pkg::*;

  localparam int NS = PIPE_STAGES;

  logic [7:0]    day_adjust_r;
  logic [NS:1]   v_r;
  logic [NS+1:1] rdy;

  // stage 1
  logic        early_m;
  logic [15:0] yy;
  logic [14:0] ysh;
  logic [25:0] a_prod;
  logic [3:0]  mm;
  logic [22:0] s1_a_r;
  logic [26:0] s1_cp_nxt, s1_cp_r;
  logic        s1_yneg_r;
  gday_t       s1_b_r;
  logic [4:0]  s1_day_r;

  // stage 2
  logic [7:0]  cent;
  logic [24:0] s2_since_nxt, s2_since_r;

  // stage 3
  logic [29:0] n_w;
  logic [27:0] s3_mag_nxt, s3_mag_r;
  logic        s3_neg_r;
  logic [24:0] s3_since_r;

  // stage 4
  logic [42:0] hy_p;
  logic [14:0] s4_q0_r;
  logic [27:0] s4_mag_r;
  logic        s4_neg_r;
  logic [24:0] s4_since_r;

  // stage 5
  logic [28:0] pd_w;
  logic [27:0] s5_pd_r;
  logic [14:0] s5_q0_r;
  logic [27:0] s5_mag_r;
  logic        s5_neg_r;
  logic [24:0] s5_since_r;

  // stage 6
  logic [27:0] hy_rem;
  logic [14:0] hy_q;
  logic [15:0] s6_hy_nxt, s6_hy_r;
  logic [24:0] s6_since_r;

  // stage 7
  logic [19:0] t_w;
  logic [19:0] t_abs;
  logic [33:0] t_p;
  logic [13:0] s7_q30_r;
  logic [17:0] s7_tmag_r;
  logic        s7_tneg_r;
  logic [15:0] s7_hy_r;
  logic [24:0] s7_since_r;

  // stage 8
  logic [17:0] r30;
  logic [13:0] q30;
  logic [14:0] s8_d30_nxt, s8_d30_r;
  logic [24:0] s8_ym_nxt, s8_ym_r;
  logic [15:0] s8_hy_r;
  logic [24:0] s8_since_r;

  // stage 9
  logic [24:0] ystart;
  logic [25:0] s9_into_nxt, s9_into_r;
  logic [15:0] s9_hy_r;

  // stage 10
  logic [26:0] ix;
  logic [27:0] x2;
  logic [3:0]  s10_hm_nxt, s10_hm_r;
  logic [25:0] s10_into_r;
  logic [15:0] s10_hy_r;

  // stage 11
  logic [26:0] hd_w;
  logic [4:0]  s11_hd_nxt, s11_hd_r;
  logic [3:0]  s11_hm_r;
  logic [15:0] s11_hy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_adjust_r <= 8'd0;
    end else if (cfg_we) begin
      day_adjust_r <= cfg_wdata;
    end
  end

  // advance a stage when it is empty or the next one advances
  always_comb begin
    rdy[NS+1] = !out_stall;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_comb begin
    early_m   = (in_greg_month <= 4'd2);
    yy        = early_m ? ({2'b00, in_greg_year} - 16'd1) : {2'b00, in_greg_year};
    ysh       = yy[14:0] + YEAR_BASE;
    a_prod    = 26'(ysh) * 26'(YEAR_MUL);
    s1_cp_nxt = 27'(yy[13:0]) * 27'(CENT_RECIP);
    mm        = early_m ? (in_greg_month + 4'd12) : in_greg_month;
  end

  always_comb begin
    cent = s1_yneg_r ? 8'd0 : s1_cp_r[CENT_SHIFT +: 8];
    s2_since_nxt = 25'(s1_a_r) + 25'(s1_b_r) + 25'(s1_day_r) - 25'(cent)
                 + 25'(cent[7:2]) + {{17{day_adjust_r[7]}}, day_adjust_r} - JD_OFFSET;
  end

  always_comb begin
    n_w = ({{5{s2_since_r[24]}}, s2_since_r} * 30'd30) + HY_BIAS;
    s3_mag_nxt = n_w[29] ? 28'(30'd0 - n_w) : n_w[27:0];
  end

  assign hy_p = 43'(s3_mag_r) * 43'(HY_RECIP);
  assign pd_w = 29'(s4_q0_r) * 29'(HY_DIV);

  always_comb begin
    hy_rem    = s5_mag_r - s5_pd_r;
    hy_q      = s5_q0_r + 15'(hy_rem >= 28'(HY_DIV));
    s6_hy_nxt = s5_neg_r ? (16'd0 - {1'b0, hy_q}) : {1'b0, hy_q};
  end

  always_comb begin
    t_w   = 20'd3 + ({{4{s6_hy_r[15]}}, s6_hy_r} * 20'd11);
    t_abs = t_w[19] ? (20'd0 - t_w) : t_w;
    t_p   = 34'(t_abs[17:0]) * 34'(D30_RECIP);
  end

  always_comb begin
    r30        = s7_tmag_r - (18'(s7_q30_r) * 18'(D30_DIV));
    q30        = s7_q30_r + 14'(r30 >= 18'(D30_DIV));
    s8_d30_nxt = s7_tneg_r ? (15'd0 - {1'b0, q30}) : {1'b0, q30};
    s8_ym_nxt  = ({{9{s7_hy_r[15]}}, s7_hy_r} - 25'd1) * 25'(HYEAR_DAYS);
  end

  always_comb begin
    ystart      = s8_ym_r + {{10{s8_d30_r[14]}}, s8_d30_r};
    s9_into_nxt = {s8_since_r[24], s8_since_r} - {ystart[24], ystart};
  end

  // count month boundaries passed; clamp to 1..12
  always_comb begin
    ix = {s9_into_r[25], s9_into_r} + 27'(HMONTH_BIAS);
    x2 = {ix, 1'b0};
    s10_hm_nxt = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if ($signed(x2) >= $signed(28'(HMONTH_LEN2) * 28'(k))) begin
        s10_hm_nxt = s10_hm_nxt + 4'd1;
      end
    end
  end

  always_comb begin
    hd_w = {s10_into_r[25], s10_into_r} - 27'(hmonth_start_f(s10_hm_r)) + 27'd1;
    if ($signed(hd_w) < 27'sd1) begin
      s11_hd_nxt = 5'd1;
    end else if ($signed(hd_w) > $signed(27'(HDAY_MAX))) begin
      s11_hd_nxt = HDAY_MAX;
    end else begin
      s11_hd_nxt = hd_w[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_a_r    <= a_prod[24:2];
      s1_cp_r   <= s1_cp_nxt;
      s1_yneg_r <= yy[15];
      s1_b_r    <= month_days_f(mm);
      s1_day_r  <= in_greg_day;
    end
    if (rdy[2]) begin
      s2_since_r <= s2_since_nxt;
    end
    if (rdy[3]) begin
      s3_mag_r   <= s3_mag_nxt;
      s3_neg_r   <= n_w[29];
      s3_since_r <= s2_since_r;
    end
    if (rdy[4]) begin
      s4_q0_r    <= hy_p[HY_SHIFT +: 15];
      s4_mag_r   <= s3_mag_r;
      s4_neg_r   <= s3_neg_r;
      s4_since_r <= s3_since_r;
    end
    if (rdy[5]) begin
      s5_pd_r    <= pd_w[27:0];
      s5_q0_r    <= s4_q0_r;
      s5_mag_r   <= s4_mag_r;
      s5_neg_r   <= s4_neg_r;
      s5_since_r <= s4_since_r;
    end
    if (rdy[6]) begin
      s6_hy_r    <= s6_hy_nxt;
      s6_since_r <= s5_since_r;
    end
    if (rdy[7]) begin
      s7_q30_r   <= t_p[D30_SHIFT +: 14];
      s7_tmag_r  <= t_abs[17:0];
      s7_tneg_r  <= t_w[19];
      s7_hy_r    <= s6_hy_r;
      s7_since_r <= s6_since_r;
    end
    if (rdy[8]) begin
      s8_d30_r   <= s8_d30_nxt;
      s8_ym_r    <= s8_ym_nxt;
      s8_hy_r    <= s7_hy_r;
      s8_since_r <= s7_since_r;
    end
    if (rdy[9]) begin
      s9_into_r <= s9_into_nxt;
      s9_hy_r   <= s8_hy_r;
    end
    if (rdy[10]) begin
      s10_hm_r   <= s10_hm_nxt;
      s10_into_r <= s9_into_r;
      s10_hy_r   <= s9_hy_r;
    end
    if (rdy[11]) begin
      s11_hd_r <= s11_hd_nxt;
      s11_hm_r <= s10_hm_r;
      s11_hy_r <= s10_hy_r;
    end
  end

  assign out_valid       = v_r[NS];
  assign out_hijri_day   = s11_hd_r;
  assign out_hijri_month = s11_hm_r;
  assign out_hijri_year  = s11_hy_r[13:0];

endmodule

FILE: test/gregorian_to_hijri_tabular_tb.sv
`timescale 1ns / 100ps
// Testbench for gregorian_to_hijri_tabular: random and directed date requests
// checked against a tabular Hijri predictor. Depends on g2h_pkg and the DUT.
module gregorian_to_hijri_tabular_tb;
  import g2h_pkg::*;

  localparam longint HIJRI_EPOCH_JD = 1948439;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_REQUESTS = 40;
  localparam int PHASE_REQUESTS = 100;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } hijri_date_t;

  class hijri_scoreboard;
    hijri_date_t expected_dates[$];
    logic signed [7:0] day_adjust = '0;
    int errors = 0;
    int checked = 0;

    function void set_adjust(logic [7:0] value);
      day_adjust = value;
    endfunction

    function hijri_date_t to_hijri(logic [13:0] gy, logic [3:0] gm, logic [4:0] gd);
      longint y, m, cent, jd, since, hy, year_start, into, hm, hd;
      hijri_date_t r;
      y = gy;
      m = gm;
      if (m <= 2) begin
        y = y - 1;
        m = m + 12;
      end
      cent = y / 100;
      jd = (1461 * (y + 4716)) / 4 + (306001 * (m + 1)) / 10000 + longint'(gd)
           + 2 - cent + cent / 4 - 1524;
      since = jd + longint'(day_adjust) - HIJRI_EPOCH_JD;
      hy = (30 * since + 10646) / 10631;
      year_start = (hy - 1) * 354 + (3 + 11 * hy) / 30;
      into = since - year_start;
      hm = (2 * (into + 28)) / 59;
      if (hm < 1) hm = 1;
      if (hm > 12) hm = 12;
      hd = since - (year_start + (59 * (hm - 1)) / 2) + 1;
      if (hd < 1) hd = 1;
      if (hd > 30) hd = 30;
      r.day = hd[4:0];
      r.month = hm[3:0];
      r.year = hy[13:0];
      return r;
    endfunction

    function void note_request(logic [13:0] gy, logic [3:0] gm, logic [4:0] gd);
      expected_dates.push_back(to_hijri(gy, gm, gd));
    endfunction

    function void check_result(hijri_date_t got);
      hijri_date_t want;
      if (expected_dates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %0d/%0d/%0d",
                 $time, got.day, got.month, got.year);
        return;
      end
      want = expected_dates.pop_front();
      checked++;
      if (got.day !== want.day || got.month !== want.month || got.year !== want.year) begin
        errors++;
        $display("%0t: result %0d mismatch, expected %0d/%0d/%0d, got %0d/%0d/%0d",
                 $time, checked, want.day, want.month, want.year,
                 got.day, got.month, got.year);
      end
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [13:0] in_greg_year;
  logic [3:0]  in_greg_month;
  logic [4:0]  in_greg_day;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  out_hijri_day;
  logic [3:0]  out_hijri_month;
  logic [13:0] out_hijri_year;

  hijri_scoreboard sb = new();
  bit hold_request = 1'b0;
  int idle_cycles = 0;

  gregorian_to_hijri_tabular dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_greg_year    (in_greg_year),
    .in_greg_month   (in_greg_month),
    .in_greg_day     (in_greg_day),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hijri_day   (out_hijri_day),
    .out_hijri_month (out_hijri_month),
    .out_hijri_year  (out_hijri_year)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(in_greg_year, in_greg_month, in_greg_day);
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_hijri_day, out_hijri_month, out_hijri_year});
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int mode;
    int span;
    bit hold_done;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(negedge clk);
        if (hold_request && !hold_done) begin
          out_stall = 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 9) < 3);
          2: out_stall = ($urandom_range(0, 3) != 0);
          default: out_stall = ~out_stall;
        endcase
      end
    end
  end

  task automatic send_request(logic [13:0] gy, logic [3:0] gm, logic [4:0] gd);
    @(negedge clk);
    in_valid = 1'b1;
    in_greg_year = gy;
    in_greg_month = gm;
    in_greg_day = gd;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_gap(int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_random();
    int pick;
    logic [13:0] gy;
    logic [3:0] gm;
    logic [4:0] gd;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      gy = 14'($urandom_range(1600, 9999));
      gm = 4'($urandom_range(1, 12));
      gd = 5'($urandom_range(1, 31));
    end else if (pick < 85) begin
      gy = 14'($urandom_range(0, 1599));
      gm = 4'($urandom_range(1, 12));
      gd = 5'($urandom_range(1, 31));
    end else begin
      gy = 14'($urandom_range(0, 16383));
      gm = 4'($urandom_range(0, 15));
      gd = 5'($urandom_range(0, 31));
    end
    send_request(gy, gm, gd);
  endtask

  task automatic run_bursts(int total, bit no_gaps);
    int sent;
    int burst;
    sent = 0;
    while (sent < total) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && sent < total; i++) begin
        send_random();
        sent++;
      end
      if (!no_gaps && $urandom_range(0, 3) != 0)
        idle_gap($urandom_range(1, 8));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_adjust(logic [7:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_adjust(value);
  endtask

  initial begin
    logic [7:0] adjust_plan[6];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_greg_year = '0;
    in_greg_month = '0;
    in_greg_day = '0;
    adjust_plan = '{8'h7F, 8'h80, 8'hFF, 8'h01, 8'h00, 8'h00};
    adjust_plan[4] = 8'($urandom_range(0, 255));
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    send_request(14'd622, 4'd7, 5'd16);
    send_request(14'd622, 4'd7, 5'd15);
    send_request(14'd0, 4'd1, 5'd1);
    send_request(14'd0, 4'd2, 5'd29);
    send_request(14'd0, 4'd3, 5'd1);
    send_request(14'd1, 4'd0, 5'd0);
    send_request(14'd2024, 4'd0, 5'd15);
    send_request(14'd2024, 4'd13, 5'd1);
    send_request(14'd2024, 4'd14, 5'd31);
    send_request(14'd2024, 4'd15, 5'd31);
    send_request(14'd2024, 4'd3, 5'd0);
    send_request(14'd2023, 4'd2, 5'd31);
    send_request(14'd2000, 4'd2, 5'd29);
    send_request(14'd1600, 4'd1, 5'd1);
    send_request(14'd1700, 4'd3, 5'd1);
    send_request(14'd9999, 4'd12, 5'd31);
    send_request(14'd16383, 4'd15, 5'd31);
    send_request(14'd16383, 4'd1, 5'd1);
    send_request(14'd2024, 4'd3, 5'd11);
    send_request(14'd2024, 4'd4, 5'd9);
    send_request(14'd2025, 4'd3, 5'd30);
    send_request(14'd100, 4'd2, 5'd28);
    send_request(14'd621, 4'd12, 5'd31);

    for (int p = 0; p < 6; p++) begin
      write_adjust(adjust_plan[p]);
      if (p == 1) begin
        hold_request = 1'b1;
        run_bursts(HOLD_REQUESTS, 1'b1);
      end
      run_bursts(PHASE_REQUESTS, 1'b0);
    end

    wait_drained();
    repeat (PIPE_STAGES + 4) @(posedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
